[rtl/core/lcls_pkg.sv]
// Shared types, command codes and the duty conversion for the LED color layer stack.
`timescale 1ns / 1ps
`default_nettype none
package lcls_pkg;

  typedef enum logic [1:0] {
    ACT_SET      = 2'd0,
    ACT_UNSET    = 2'd1,
    ACT_OVERRIDE = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  layer_id;
    logic [23:0] rgb_value;
  } cmd_beat_t;

  typedef struct packed {
    logic [15:0] red_duty;
    logic [15:0] green_duty;
    logic [15:0] blue_duty;
  } duty_beat_t;

  // Contents of one stack slot.
  typedef struct packed {
    logic        used;
    logic [7:0]  owner;
    logic [23:0] rgb;
  } cell_data_t;

  localparam int unsigned CELL_W = $bits(cell_data_t);

  // Controls broadcast from the sequencer to every slot cell.
  typedef struct packed {
    logic        go;
    logic        adv;
    logic        stop;
    logic        is_set;
    logic        pull;
    logic [7:0]  id;
    logic [23:0] rgb;
  } cell_ctrl_t;

  // A byte times 257 is the byte written twice.
  function automatic duty_beat_t rgb_to_duty(input logic [23:0] c);
    duty_beat_t d;
    d.red_duty   = {c[23:16], c[23:16]};
    d.green_duty = {c[15:8], c[15:8]};
    d.blue_duty  = {c[7:0], c[7:0]};
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/core/led_color_layer_stack_core.sv]
// Top level of the LED color layer stack: slot cell chain, scan sequencer and duty register.
//
//   channel  dir  handshake                payload
//   cmd      in   cmd_valid / cmd_stall    cmd_beat_t  (action, layer_id, rgb_value)
//   duty     out  duty_valid / duty_stall  duty_beat_t (red, green, blue duty)
//
// An override is written straight into the duty register. A set or unset sends a token
// up the slot chain, one slot per cycle: a set ends at the matching or first free slot,
// or at the top slot of a full stack; an unset runs up to the end of the used slots,
// while slots above the removed one shift down. A stalled result holds the scan in place.
// Reset clears all used flags and the token at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module led_color_layer_stack_core
  import lcls_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  cmd_beat_t  cmd,
  output logic       duty_valid,
  input  logic       duty_stall,
  output duty_beat_t duty
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t      state, state_next;
  logic        is_set;
  logic [7:0]  id;
  logic [23:0] rgb;
  logic        pull, pull_next;
  logic        have_top, have_top_next;
  logic [23:0] top_rgb, top_rgb_next;

  cell_ctrl_t       ctrl;
  logic [SLOTS-1:0] tok;
  logic [SLOTS-1:0] match;
  cell_data_t       cell_data [SLOTS];
  cell_data_t       cell_nbr  [SLOTS];

  logic        accept, launch, ov_accept, go, done, res, out_load;
  logic [23:0] res_rgb, out_rgb;
  logic        sel_match;
  cell_data_t  sel_data, sel_nbr;

  assign cmd_stall = (state != S_IDLE) || (duty_valid && duty_stall);
  assign accept    = cmd_valid && !cmd_stall;
  assign launch    = accept && ((cmd.action == ACT_SET) || (cmd.action == ACT_UNSET));
  assign ov_accept = accept && (cmd.action == ACT_OVERRIDE);
  assign go        = (state == S_WALK) && !(duty_valid && duty_stall);

  assign ctrl.go     = go;
  assign ctrl.adv    = launch || go;
  assign ctrl.stop   = go && done;
  assign ctrl.is_set = is_set;
  assign ctrl.pull   = pull;
  assign ctrl.id     = id;
  assign ctrl.rgb    = rgb;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k < SLOTS - 1) begin : g_nbr
      assign cell_nbr[k] = cell_data[k+1];
    end else begin : g_top
      assign cell_nbr[k] = '0;
    end
    lcls_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .tok_in ((k == 0) ? launch : tok[(k == 0) ? 0 : k-1]),
      .nbr    (cell_nbr[k]),
      .tok    (tok[k]),
      .data   (cell_data[k]),
      .match  (match[k])
    );
  end

  // The token is one-hot during a scan, so an AND-OR picks the visited slot.
  always_comb begin
    sel_data  = '0;
    sel_nbr   = '0;
    sel_match = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      sel_data  = cell_data_t'(sel_data | (cell_data[k] & {CELL_W{tok[k]}}));
      sel_nbr   = cell_data_t'(sel_nbr | (cell_nbr[k] & {CELL_W{tok[k]}}));
      sel_match = sel_match | (match[k] & tok[k]);
    end
  end

  always_comb begin
    done          = 1'b0;
    res           = 1'b0;
    res_rgb       = rgb;
    pull_next     = pull;
    have_top_next = have_top;
    top_rgb_next  = top_rgb;
    if (is_set) begin
      if (sel_match) begin
        done = 1'b1;
        res  = !sel_nbr.used;
      end else if (!sel_data.used) begin
        done = 1'b1;
        res  = 1'b1;
      end else if (tok[SLOTS-1]) begin
        done = 1'b1;
      end
    end else if (pull || sel_match) begin
      pull_next = 1'b1;
      if (sel_nbr.used) begin
        have_top_next = 1'b1;
        top_rgb_next  = sel_nbr.rgb;
      end else begin
        done    = 1'b1;
        res     = have_top;
        res_rgb = top_rgb;
      end
    end else if (sel_data.used) begin
      have_top_next = 1'b1;
      top_rgb_next  = sel_data.rgb;
      if (tok[SLOTS-1]) begin
        done    = 1'b1;
        res     = 1'b1;
        res_rgb = sel_data.rgb;
      end
    end else begin
      done    = 1'b1;
      res     = have_top;
      res_rgb = top_rgb;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (launch) state_next = S_WALK;
      S_WALK: if (go && done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      is_set   <= (cmd.action == ACT_SET);
      id       <= cmd.layer_id;
      rgb      <= cmd.rgb_value;
      pull     <= 1'b0;
      have_top <= 1'b0;
    end else if (go) begin
      pull     <= pull_next;
      have_top <= have_top_next;
      top_rgb  <= top_rgb_next;
    end
  end

  assign out_load = ov_accept || (go && done && res);
  assign out_rgb  = ov_accept ? cmd.rgb_value : res_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_valid <= 1'b0;
    end else if (out_load) begin
      duty_valid <= 1'b1;
    end else if (!duty_stall) begin
      duty_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      duty <= rgb_to_duty(out_rgb);
    end
  end

endmodule
`default_nettype wire

[rtl/core/lcls_cell.sv]
// One slot of the layer stack: owner, color, used flag and the scan token.
`timescale 1ns / 1ps
`default_nettype none
module lcls_cell
  import lcls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       tok_in,
  input  cell_data_t nbr,
  output logic       tok,
  output cell_data_t data,
  output logic       match
);

  logic        used;
  logic [7:0]  owner;
  logic [23:0] rgb;

  assign data  = '{used: used, owner: owner, rgb: rgb};
  assign match = used && (owner == ctrl.id);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok  <= 1'b0;
      used <= 1'b0;
    end else begin
      if (ctrl.stop) begin
        tok <= 1'b0;
      end else if (ctrl.adv) begin
        tok <= tok_in;
      end
      if (ctrl.go && tok) begin
        if (ctrl.is_set) begin
          if (match) begin
            rgb <= ctrl.rgb;
          end else if (!used) begin
            used  <= 1'b1;
            owner <= ctrl.id;
            rgb   <= ctrl.rgb;
          end
        end else if (ctrl.pull || match) begin
          // Removal: this slot takes over its upper neighbor, closing the gap.
          used  <= nbr.used;
          owner <= nbr.owner;
          rgb   <= nbr.rgb;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/lcls_checker.sv]
// Port-level checks for the LED color layer stack core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lcls_checker
  import lcls_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_stall,
  input cmd_beat_t  cmd,
  input logic       duty_valid,
  input logic       duty_stall,
  input duty_beat_t duty
);

  // A held result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    duty_valid && duty_stall |=> duty_valid && $stable(duty))
    else $error("duty beat changed while stalled");

  assert property (@(posedge clk)
    rst |=> !duty_valid)
    else $error("result beat right after reset");

  // Every result is a color with each byte repeated.
  assert property (@(posedge clk) disable iff (rst)
    duty_valid |-> (duty.red_duty[15:8] == duty.red_duty[7:0]) &&
                   (duty.green_duty[15:8] == duty.green_duty[7:0]) &&
                   (duty.blue_duty[15:8] == duty.blue_duty[7:0]))
    else $error("duty is not a byte times 257");

  // An override shows its red and blue bytes in the very next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.action == ACT_OVERRIDE) |=>
      duty_valid && (duty.red_duty[7:0] == $past(cmd.rgb_value[23:16])) &&
      (duty.blue_duty[7:0] == $past(cmd.rgb_value[7:0])))
    else $error("override color not driven");

  // A set or unset occupies the slot scan, so the next command waits.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall &&
    ((cmd.action == ACT_SET) || (cmd.action == ACT_UNSET)) |=> cmd_stall)
    else $error("command taken during a slot scan");

endmodule

bind led_color_layer_stack_core lcls_checker u_lcls_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd_valid),
  .cmd_stall  (cmd_stall),
  .cmd        (cmd),
  .duty_valid (duty_valid),
  .duty_stall (duty_stall),
  .duty       (duty)
);
`default_nettype wire
